// ===== rtl/core/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the lidar packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    // Body bytes after the header: frame overhead minus header bytes.
    localparam logic [8:0] BODY_OVERHEAD = 9'd6;

    localparam logic [7:0] HUNT_LIMIT_RESET = 8'd100;
    localparam logic [6:0] MAX_POINTS_RESET = 7'd25;

    // Configuration register indexes.
    localparam logic CFG_HUNT_LIMIT = 1'b0;
    localparam logic CFG_MAX_POINTS = 1'b1;

    // Input request codes.
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Parser phases.
    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;
    localparam logic [1:0] PH_BODY  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_NO_HEADER = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT = 3'd4;

    typedef struct packed {
        logic       is_header;
        logic [7:0] data_byte;
        logic       point_type;
        logic [6:0] point_count;
        logic [2:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] hunt_limit;
        logic [6:0] max_points;
    } cfg_t;

endpackage

// ===== rtl/core/lpd_parser.sv =====
// ----------------------------------------------------------------------------
// lpd_parser
// Framing state and the per-item decision logic of the deframer.
// ----------------------------------------------------------------------------
module lpd_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             req_type,
    input  logic [7:0]       rx_byte,
    input  lpd_pkg::cfg_t    cfg,
    output logic             res_valid,
    output lpd_pkg::result_t res
);

    logic [1:0] phase_reg,         phase_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic [7:0] hunt_count_reg,    hunt_count_next;
    logic [7:0] type_hold_reg,     type_hold_next;
    logic [6:0] count_hold_reg,    count_hold_next;
    logic [8:0] bytes_left_reg,    bytes_left_next;

    logic [7:0] hunt_count_inc;

    assign hunt_count_inc = hunt_count_reg + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        previous_byte_next = previous_byte_reg;
        hunt_count_next    = hunt_count_reg;
        type_hold_next     = type_hold_reg;
        count_hold_next    = count_hold_reg;
        bytes_left_next    = bytes_left_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (req_type == lpd_pkg::REQ_TIMEOUT)
        begin
            res_valid          = 1'b1;
            res.status         = lpd_pkg::ST_TIMEOUT;
            res.last           = 1'b1;
            phase_next         = lpd_pkg::PH_HUNT;
            previous_byte_next = '0;
            hunt_count_next    = '0;
        end
        else
        begin
            unique case (phase_reg)
                lpd_pkg::PH_HUNT:
                begin
                    hunt_count_next = hunt_count_inc;
                    if (previous_byte_reg == lpd_pkg::SYNC_FIRST &&
                        rx_byte == lpd_pkg::SYNC_SECOND)
                    begin
                        phase_next = lpd_pkg::PH_TYPE;
                    end
                    else
                    begin
                        previous_byte_next = rx_byte;
                        if (hunt_count_inc >= cfg.hunt_limit)
                        begin
                            res_valid          = 1'b1;
                            res.status         = lpd_pkg::ST_NO_HEADER;
                            res.last           = 1'b1;
                            previous_byte_next = '0;
                            hunt_count_next    = '0;
                        end
                    end
                end
                lpd_pkg::PH_TYPE:
                begin
                    type_hold_next = rx_byte;
                    phase_next     = lpd_pkg::PH_COUNT;
                end
                lpd_pkg::PH_COUNT:
                begin
                    res_valid = 1'b1;
                    // Type is checked ahead of the count.
                    priority if (type_hold_reg[7:1] != 7'd0)
                    begin
                        res.status = lpd_pkg::ST_BAD_TYPE;
                        res.last   = 1'b1;
                    end
                    else if (rx_byte == 8'd0 || rx_byte > {1'b0, cfg.max_points})
                    begin
                        res.status = lpd_pkg::ST_BAD_COUNT;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        res.is_header   = 1'b1;
                        res.point_type  = type_hold_reg[0];
                        res.point_count = rx_byte[6:0];
                        res.status      = lpd_pkg::ST_OK;
                        count_hold_next = rx_byte[6:0];
                        bytes_left_next = lpd_pkg::BODY_OVERHEAD
                                          + {1'b0, rx_byte[6:0], 1'b0};
                        phase_next      = lpd_pkg::PH_BODY;
                    end
                    if (res.last)
                    begin
                        phase_next         = lpd_pkg::PH_HUNT;
                        previous_byte_next = '0;
                        hunt_count_next    = '0;
                    end
                end
                lpd_pkg::PH_BODY:
                begin
                    res_valid     = 1'b1;
                    res.data_byte = rx_byte;
                    res.status    = lpd_pkg::ST_OK;
                    if (bytes_left_reg <= 9'd1)
                    begin
                        res.last           = 1'b1;
                        bytes_left_next    = '0;
                        phase_next         = lpd_pkg::PH_HUNT;
                        previous_byte_next = '0;
                        hunt_count_next    = '0;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 9'd1;
                    end
                end
                default:
                begin
                    phase_next = lpd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= lpd_pkg::PH_HUNT;
            previous_byte_reg <= '0;
            hunt_count_reg    <= '0;
            type_hold_reg     <= '0;
            count_hold_reg    <= '0;
            bytes_left_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            previous_byte_reg <= previous_byte_next;
            hunt_count_reg    <= hunt_count_next;
            type_hold_reg     <= type_hold_next;
            count_hold_reg    <= count_hold_next;
            bytes_left_reg    <= bytes_left_next;
        end
    end

endmodule

// ===== rtl/core/lidar_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_deframer
// Sync-pair and length-field deframer for a serial lidar byte stream.
// ----------------------------------------------------------------------------
// The block takes one item (a received byte or a read timeout) per clock
// cycle while the output is not stalled and gives at most one result per
// item. An item passes through an input register and the framing logic
// into the result register. A stall on the output holds the result
// register and, through it, the input register.
// Configuration is written through cfg_we, cfg_index and cfg_data.
module lidar_packet_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_header,
    output logic [7:0] data_byte,
    output logic       point_type,
    output logic [6:0] point_count,
    output logic [2:0] status,
    output logic       last
);

    lpd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic             req_type_reg;
    logic [7:0]       rx_byte_reg;
    logic             out_valid_reg;
    lpd_pkg::result_t out_reg;
    lpd_pkg::result_t res;
    logic             res_valid;
    logic             advance;
    logic             fire;

    // The result register can take a new value when it is empty or drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hunt_limit <= lpd_pkg::HUNT_LIMIT_RESET;
            cfg_reg.max_points <= lpd_pkg::MAX_POINTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpd_pkg::CFG_HUNT_LIMIT: cfg_reg.hunt_limit <= cfg_data;
                lpd_pkg::CFG_MAX_POINTS: cfg_reg.max_points <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            req_type_reg <= req_type;
            rx_byte_reg  <= rx_byte;
        end
    end

    lpd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req_type  (req_type_reg),
        .rx_byte   (rx_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_header   = out_reg.is_header;
    assign data_byte   = out_reg.data_byte;
    assign point_type  = out_reg.point_type;
    assign point_count = out_reg.point_count;
    assign status      = out_reg.status;
    assign last        = out_reg.last;

endmodule
